// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define DMR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define DMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dmr_pkg.sv =====
`default_nettype none

package dmr_pkg;

  localparam int MAX_ITEMS      = 8;
  localparam int MAX_ITEM_CHARS = 16;

  localparam int ITEM_IDX_W = $clog2(MAX_ITEMS);
  localparam int CHAR_IDX_W = $clog2(MAX_ITEM_CHARS);
  localparam int CNT_W      = ITEM_IDX_W + 1;
  localparam int POS_W      = CHAR_IDX_W + 1;
  localparam int ADDR_W     = ITEM_IDX_W + CHAR_IDX_W;
  localparam int CFG_IDX_W  = 2;

  // opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // parser states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RECV = 2'd1;
  localparam logic [1:0] ST_HELD = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
  localparam logic [1:0] ERR_ITEM_LEN = 2'd2;
  localparam logic [1:0] ERR_MSG_LEN  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP   = 2'd2;

  localparam logic [7:0] START_RST = 8'd60;
  localparam logic [7:0] STOP_RST  = 8'd62;
  localparam logic [7:0] SEP_RST   = 8'd44;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [7:0]            data_byte;
    logic [ITEM_IDX_W-1:0] item_index;
    logic [CHAR_IDX_W-1:0] char_index;
  } dmr_in_t;

  typedef struct packed {
    logic             message_ready;
    logic [CNT_W-1:0] item_count;
    logic [1:0]       error_code;
    logic [1:0]       parser_state;
    logic [7:0]       char_out;
  } dmr_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dmr_if.sv =====
`default_nettype none

interface dmr_in_if import dmr_pkg::*; ();
  logic    valid;
  logic    ready;
  dmr_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dmr_out_if import dmr_pkg::*; ();
  logic     valid;
  logic     ready;
  dmr_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/delimited_message_receiver.sv =====
// Channel   Dir  Payload
// in_chan   in   opcode, data_byte, item_index, char_index
// out_chan  out  message_ready, item_count, error_code, parser_state, char_out
// cfg_*     in   write enable, register index, 8-bit data
//
// One item per cycle while out_chan is not stalled; each result appears in the cycle after its item is taken.
// The parser state and the character store update at the accepting edge; the
// store read for a read op is registered at that same edge beside the status.
// A stalled result holds in the output register and in_chan.ready drops.
// Reset is synchronous; the character store and item lengths are not cleared.
`default_nettype none

module delimited_message_receiver
  import dmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  dmr_in_if.sink               in_chan,
  dmr_out_if.source            out_chan
);

`include "assert_macros.svh"

  logic [7:0] start_char_r, stop_char_r, sep_char_r;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [CNT_W-1:0] items_r, items_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [7:0]       store_mem [2**ADDR_W];
  logic [POS_W-1:0] item_len_r [MAX_ITEMS];

  logic             out_valid_r;
  logic             msg_ready_r;
  logic [CNT_W-1:0] count_r;
  logic [1:0]       err_out_r;
  logic [1:0]       state_out_r;
  logic             rd_ok_r;
  logic [7:0]       rd_data_r;

  logic       accept;
  dmr_in_t    req;
  logic [7:0] b;
  logic       blank;
  logic       store_we;
  logic       len_we;
  logic       rd_ok;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign req           = in_chan.payload;
  assign b             = req.data_byte;
  assign blank         = (b == CH_SPACE) || (b == CH_NEWLINE);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= START_RST;
      stop_char_r  <= STOP_RST;
      sep_char_r   <= SEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START: start_char_r <= cfg_data;
        CFG_STOP:  stop_char_r  <= cfg_data;
        CFG_SEP:   sep_char_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser next state
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    items_nxt = items_r;
    pos_nxt   = pos_r;
    store_we  = 1'b0;
    len_we    = 1'b0;
    unique case (req.opcode)
      OP_PUSH: begin
        if (state_r == ST_IDLE) begin
          if (b == start_char_r) begin
            state_nxt = ST_RECV;
            err_nxt   = ERR_NONE;
            items_nxt = '0;
            pos_nxt   = '0;
          end else if (!blank) begin
            err_nxt   = ERR_ILLEGAL;
            items_nxt = '0;
            pos_nxt   = '0;
          end
        end else if (state_r == ST_RECV) begin
          priority if (b == start_char_r) begin
            state_nxt = ST_IDLE;
            err_nxt   = ERR_ILLEGAL;
            items_nxt = '0;
            pos_nxt   = '0;
          end else if (b == stop_char_r) begin
            state_nxt = ST_HELD;
            pos_nxt   = '0;
            if (pos_r != '0 && items_r < CNT_W'(MAX_ITEMS)) begin
              len_we    = 1'b1;
              items_nxt = items_r + 1'b1;
            end
          end else if (b == sep_char_r) begin
            priority if (pos_r == '0) begin
              state_nxt = ST_IDLE;
              err_nxt   = ERR_ITEM_LEN;
              items_nxt = '0;
              pos_nxt   = '0;
            end else if (items_r >= CNT_W'(MAX_ITEMS - 1)) begin
              state_nxt = ST_IDLE;
              err_nxt   = ERR_MSG_LEN;
              items_nxt = '0;
              pos_nxt   = '0;
            end else begin
              len_we    = 1'b1;
              items_nxt = items_r + 1'b1;
              pos_nxt   = '0;
            end
          end else if (pos_r >= POS_W'(MAX_ITEM_CHARS)) begin
            state_nxt = ST_IDLE;
            err_nxt   = ERR_ITEM_LEN;
            items_nxt = '0;
            pos_nxt   = '0;
          end else if (!blank && items_r < CNT_W'(MAX_ITEMS)) begin
            store_we = 1'b1;
            pos_nxt  = pos_r + 1'b1;
          end
        end
      end
      OP_RESET: begin
        state_nxt = ST_IDLE;
        err_nxt   = ERR_NONE;
        items_nxt = '0;
        pos_nxt   = '0;
      end
      OP_READ, OP_NOP: ;
      default: ;
    endcase
  end

  assign rd_ok = (req.opcode == OP_READ) && (state_r == ST_HELD)
              && ({1'b0, req.item_index} < items_r)
              && ({1'b0, req.char_index} < item_len_r[req.item_index]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_r   <= ERR_NONE;
      items_r <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
      items_r <= items_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // character store: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      store_mem[{items_r[ITEM_IDX_W-1:0], pos_r[CHAR_IDX_W-1:0]}] <= b;
    end
    if (accept) begin
      rd_data_r <= store_mem[{req.item_index, req.char_index}];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && len_we) begin
      item_len_r[items_r[ITEM_IDX_W-1:0]] <= pos_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg_ready_r <= (state_nxt == ST_HELD);
      count_r     <= (state_nxt == ST_HELD) ? items_nxt : '0;
      err_out_r   <= err_nxt;
      state_out_r <= state_nxt;
      rd_ok_r     <= rd_ok;
    end
  end

  assign out_chan.valid                 = out_valid_r;
  assign out_chan.payload.message_ready = msg_ready_r;
  assign out_chan.payload.item_count    = count_r;
  assign out_chan.payload.error_code    = err_out_r;
  assign out_chan.payload.parser_state  = state_out_r;
  assign out_chan.payload.char_out      = rd_ok_r ? rd_data_r : 8'd0;

  `DMR_ASSERT_ALWAYS(a_recv_room, (state_r != ST_RECV) || (items_r < CNT_W'(MAX_ITEMS)), "receiving with full item table")
  `DMR_ASSERT_ALWAYS(a_pos_range, pos_r <= POS_W'(MAX_ITEM_CHARS), "char position past item limit")
  `DMR_ASSERT_ALWAYS(a_ready_match, !out_valid_r || (msg_ready_r == (state_out_r == ST_HELD)), "message_ready disagrees with parser_state")
  `DMR_ASSERT_NEXT(a_read_unheld, accept && (state_r != ST_HELD), out_chan.payload.char_out == 8'd0, "read without held message returned data")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dmr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class frame_scoreboard;
    logic [7:0]       start_ch, stop_ch, sep_ch;
    logic [1:0]       state_q, err_q;
    logic [CNT_W-1:0] items_done;
    logic [POS_W-1:0] char_pos;
    logic [7:0]       chars [MAX_ITEMS][MAX_ITEM_CHARS];
    logic [POS_W-1:0] lens [MAX_ITEMS];
    dmr_out_t         pending_status [$];
    int               fail_count, n_checked, n_chars_read;
    int               faults [4];

    function new();
      start_ch = START_RST;
      stop_ch  = STOP_RST;
      sep_ch   = SEP_RST;
      drop(ERR_NONE);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_START: start_ch = val;
        CFG_STOP:  stop_ch = val;
        CFG_SEP:   sep_ch = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    // store contents are left alone; only entries of the current message are read
    function void clear_items();
      items_done = '0;
      char_pos   = '0;
    endfunction

    function void drop(logic [1:0] e);
      clear_items();
      state_q = ST_IDLE;
      err_q   = e;
      if (e != ERR_NONE) faults[e]++;
    endfunction

    function bit blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_NEWLINE;
    endfunction

    function void close_item();
      if (items_done < MAX_ITEMS) begin
        lens[items_done[ITEM_IDX_W-1:0]] = char_pos;
        items_done++;
      end
      char_pos = '0;
    endfunction

    function void note_accepted(dmr_in_t it);
      dmr_out_t   r;
      logic [7:0] ch;
      logic [7:0] b;
      ch = '0;
      b  = it.data_byte;
      case (it.opcode)
        OP_PUSH: begin
          if (state_q == ST_IDLE) begin
            if (b == start_ch) begin
              clear_items();
              state_q = ST_RECV;
              err_q   = ERR_NONE;
            end else if (!blank(b)) begin
              drop(ERR_ILLEGAL);
            end
          end else if (state_q == ST_RECV) begin
            if (b == start_ch) begin
              drop(ERR_ILLEGAL);
            end else if (b == stop_ch) begin
              if (char_pos > 0) close_item();
              state_q = ST_HELD;
            end else if (b == sep_ch) begin
              if (char_pos == 0) drop(ERR_ITEM_LEN);
              else if (items_done >= MAX_ITEMS - 1) drop(ERR_MSG_LEN);
              else close_item();
            end else if (char_pos >= MAX_ITEM_CHARS) begin
              // blanks count here too: a full item takes no further byte
              drop(ERR_ITEM_LEN);
            end else if (!blank(b) && items_done < MAX_ITEMS) begin
              chars[items_done[ITEM_IDX_W-1:0]][char_pos[CHAR_IDX_W-1:0]] = b;
              char_pos++;
            end
          end
        end
        OP_READ: begin
          if (state_q == ST_HELD && it.item_index < items_done &&
              it.char_index < lens[it.item_index])
            ch = chars[it.item_index][it.char_index];
        end
        OP_RESET: drop(ERR_NONE);
        default: ;
      endcase
      if (ch != 0) n_chars_read++;
      r.message_ready = (state_q == ST_HELD);
      r.item_count    = (state_q == ST_HELD) ? items_done : '0;
      r.error_code    = err_q;
      r.parser_state  = state_q;
      r.char_out      = ch;
      pending_status.push_back(r);
    endfunction

    task report(string what);
      fail_count++;
      // keep the log short when something is badly broken
      if (fail_count <= 50) $display("[%0t] result %0d: %s", $time, n_checked, what);
    endtask

    task compare_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
    endtask

    task check_status(dmr_out_t got);
      dmr_out_t want;
      n_checked++;
      if (pending_status.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending_status.pop_front();
      compare_field("message_ready", 8'(got.message_ready), 8'(want.message_ready));
      compare_field("item_count", 8'(got.item_count), 8'(want.item_count));
      compare_field("error_code", 8'(got.error_code), 8'(want.error_code));
      compare_field("parser_state", 8'(got.parser_state), 8'(want.parser_state));
      compare_field("char_out", got.char_out, want.char_out);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  dmr_in_if  in_chan ();
  dmr_out_if out_chan ();

  frame_scoreboard sb;
  bit idle_on;
  bit hold_req;
  int sent_items;

  delimited_message_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_chan.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) sb.check_status(out_chan.payload);
  end

  // valid stays high after acceptance so back-to-back items need not drop valid between them
  task automatic send(dmr_in_t it);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_accepted(it);
    sent_items++;
  endtask

  task automatic push_byte(logic [7:0] b);
    dmr_in_t it;
    it.opcode     = OP_PUSH;
    it.data_byte  = b;
    it.item_index = ITEM_IDX_W'($urandom_range(0, MAX_ITEMS - 1));
    it.char_index = CHAR_IDX_W'($urandom_range(0, MAX_ITEM_CHARS - 1));
    send(it);
  endtask

  task automatic read_char(int item, int pos);
    dmr_in_t it;
    it.opcode     = OP_READ;
    it.data_byte  = 8'($urandom_range(0, 255));
    it.item_index = ITEM_IDX_W'(item);
    it.char_index = CHAR_IDX_W'(pos);
    send(it);
  endtask

  task automatic command(logic [1:0] op);
    dmr_in_t it;
    it.opcode     = op;
    it.data_byte  = 8'($urandom_range(0, 255));
    it.item_index = ITEM_IDX_W'($urandom_range(0, MAX_ITEMS - 1));
    it.char_index = CHAR_IDX_W'($urandom_range(0, MAX_ITEM_CHARS - 1));
    send(it);
  endtask

  // a byte that lands in the item store under the current delimiters
  function automatic logic [7:0] body_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == sb.start_ch || b == sb.stop_ch || b == sb.sep_ch ||
           b == CH_SPACE || b == CH_NEWLINE);
    return b;
  endfunction

  task automatic send_frame(int n_items, int min_len, int max_len, bit trailing);
    int         len;
    logic [7:0] b;
    push_byte(sb.start_ch);
    for (int i = 0; i < n_items; i++) begin
      len = $urandom_range(min_len, max_len);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 7) == 0) begin
          b = ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_NEWLINE;
          if (b != sb.start_ch && b != sb.stop_ch && b != sb.sep_ch) push_byte(b);
        end
        push_byte(body_char());
      end
      if (i < n_items - 1 || trailing) push_byte(sb.sep_ch);
    end
    push_byte(sb.stop_ch);
  endtask

  task automatic overlong_item();
    push_byte(sb.start_ch);
    repeat (MAX_ITEM_CHARS) push_byte(body_char());
    push_byte(($urandom_range(0, 1) != 0) ? body_char() : CH_SPACE);
  endtask

  task automatic too_many_items();
    push_byte(sb.start_ch);
    repeat (MAX_ITEMS) begin
      push_byte(body_char());
      push_byte(sb.sep_ch);
    end
  endtask

  task automatic random_episode();
    int pick, n, max_len;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      n       = ($urandom_range(0, 9) == 0) ? MAX_ITEMS : $urandom_range(0, MAX_ITEMS);
      max_len = ($urandom_range(0, 4) == 0) ? MAX_ITEM_CHARS : 6;
      send_frame(n, 1, max_len, $urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 6)) begin
        read_char((n == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_ITEMS - 1)
                                                        : $urandom_range(0, n - 1),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_ITEM_CHARS - 1)
                                              : $urandom_range(0, max_len - 1));
      end
      if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 255)));
      command(OP_RESET);
    end else if (pick < 75) begin
      overlong_item();
    end else if (pick < 80) begin
      too_many_items();
    end else if (pick < 85) begin
      push_byte(sb.start_ch);
      push_byte(body_char());
      push_byte(sb.start_ch);
    end else if (pick < 88) begin
      push_byte(sb.start_ch);
      if ($urandom_range(0, 1) != 0) begin
        push_byte(body_char());
        push_byte(sb.sep_ch);
      end
      push_byte(sb.sep_ch);
    end else begin
      repeat ($urandom_range(1, 8)) command(2'($urandom_range(0, 3)));
      if ($urandom_range(0, 1) != 0) command(OP_RESET);
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = sent_items + count;
    while (sent_items < stop_at) random_episode();
  endtask

  // drain everything outstanding before touching the registers or ending
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_delimiters(logic [7:0] s, logic [7:0] p, logic [7:0] e, bit poke_unused);
    cfg_write(CFG_START, s);
    cfg_write(CFG_STOP, p);
    cfg_write(CFG_SEP, e);
    if (poke_unused) cfg_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] s, p, e;
    sb = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.payload <= '0;
    idle_on  = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset delimiters
    push_byte(CH_SPACE);
    push_byte(CH_NEWLINE);
    push_byte(8'hFF);              // illegal while idle
    command(OP_NOP);
    push_byte(START_RST);
    push_byte(SEP_RST);            // empty item
    push_byte(START_RST);
    push_byte(STOP_RST);           // held with no items
    read_char(0, 0);
    push_byte(8'h41);              // ignored while held
    command(OP_RESET);
    push_byte(START_RST);
    push_byte(8'h00);
    push_byte(CH_SPACE);
    push_byte(8'h7F);
    push_byte(SEP_RST);
    push_byte(START_RST);          // start inside a message
    push_byte(START_RST);
    push_byte(8'h71);
    push_byte(SEP_RST);
    push_byte(STOP_RST);           // trailing separator
    read_char(0, 0);
    read_char(0, 1);
    read_char(MAX_ITEMS - 1, MAX_ITEM_CHARS - 1);
    command(OP_RESET);
    overlong_item();
    too_many_items();
    send_frame(MAX_ITEMS, MAX_ITEM_CHARS, MAX_ITEM_CHARS, 1'b0);
    read_char(MAX_ITEMS - 1, MAX_ITEM_CHARS - 1);
    read_char(0, 0);
    command(OP_RESET);

    settle();
    load_delimiters(8'h00, 8'hFF, 8'h80, 1'b0);
    idle_on  = 1'b1;
    hold_req = 1'b1;
    run_random(330);

    settle();
    load_delimiters(8'hFF, 8'h00, CH_SPACE, 1'b0);
    run_random(330);

    settle();
    load_delimiters(CH_NEWLINE, CH_SPACE, 8'($urandom_range(33, 255)), 1'b1);
    run_random(330);

    settle();
    s = 8'($urandom_range(0, 255));
    do p = 8'($urandom_range(0, 255)); while (p == s);
    do e = 8'($urandom_range(0, 255)); while (e == s || e == p);
    load_delimiters(s, p, e, 1'b1);
    run_random(330);

    settle();
    load_delimiters(START_RST, STOP_RST, SEP_RST, 1'b0);
    idle_on = 1'b0;
    run_random(330);

    settle();
    $display("Sent %0d items over six delimiter phases; %0d results checked, %0d chars read.",
             sent_items, sb.n_checked, sb.n_chars_read);
    $display("Faults exercised: %0d illegal char, %0d item length, %0d message length.",
             sb.faults[ERR_ILLEGAL], sb.faults[ERR_ITEM_LEN], sb.faults[ERR_MSG_LEN]);
    if (sb.fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== delimited_message_receiver.f =====
+incdir+hw/rtl
hw/rtl/dmr_pkg.sv
hw/rtl/dmr_if.sv
hw/rtl/delimited_message_receiver.sv
bench/testbench.sv
